/* rtl/bwr_pkg.sv */
// Package for the bilinear warp resampler.
// Holds field widths, opcodes, register indexes and frame defaults.
// No dependencies.
package bwr_pkg;

  localparam int PIX_W       = 24;
  localparam int CRD_W       = 8;
  localparam int COEF_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int ADDR_W      = 16;
  localparam int STORE_DEPTH = 65536;
  localparam int COORD_W     = 12;
  localparam int SUM_W       = 52;
  localparam int IDX_W       = 4;

  localparam int DEF_FRAME_WIDTH  = 256;
  localparam int DEF_FRAME_HEIGHT = 256;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic [IDX_W-1:0] REG_X_COL   = 4'd0;
  localparam logic [IDX_W-1:0] REG_X_ROW   = 4'd1;
  localparam logic [IDX_W-1:0] REG_X_CROSS = 4'd2;
  localparam logic [IDX_W-1:0] REG_X_OFF   = 4'd3;
  localparam logic [IDX_W-1:0] REG_Y_COL   = 4'd4;
  localparam logic [IDX_W-1:0] REG_Y_ROW   = 4'd5;
  localparam logic [IDX_W-1:0] REG_Y_CROSS = 4'd6;
  localparam logic [IDX_W-1:0] REG_Y_OFF   = 4'd7;

  localparam logic [COEF_W-1:0] COEF_UNITY = 32'h0001_0000;

  typedef logic signed [SUM_W-1:0] sum_t;

endpackage

/* rtl/bilinear_warp_resampler.sv */
// Bilinear warp resampler: frame store plus coordinate mapping pipeline.
// Depends on bwr_pkg.
// A fetch passes through stage 1, stage 2, stage 3 and the output register before it reaches out_*.
// Throughput: one item per cycle; the pipeline stalls as a whole only when a
// result is held by out_stall. Stores and fetches share the single frame memory port.
// Reset: clears pipeline valids and loads the identity coefficients; the frame
// store is not cleared and holds undefined data until written.
module bilinear_warp_resampler #(
  parameter int FRAME_WIDTH  = bwr_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = bwr_pkg::DEF_FRAME_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [bwr_pkg::CRD_W-1:0]     in_row,
  input  logic [bwr_pkg::CRD_W-1:0]     in_col,
  input  logic [bwr_pkg::PIX_W-1:0]     in_pixel_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bwr_pkg::CRD_W-1:0]     out_row,
  output logic [bwr_pkg::CRD_W-1:0]     out_col,
  output logic [bwr_pkg::PIX_W-1:0]     out_pixel_out,
  output logic                          out_of_range,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bwr_pkg::IDX_W-1:0]     cfg_index,
  input  logic [bwr_pkg::COEF_W-1:0]    cfg_data
);
  import bwr_pkg::*;

  // Coefficients
  logic signed [COEF_W-1:0] kxc_r, kxr_r, kxx_r, kxo_r;
  logic signed [COEF_W-1:0] kyc_r, kyr_r, kyx_r, kyo_r;

  // Stage 1: first products
  logic                      v1_r, op1_r;
  logic [CRD_W-1:0]          row1_r, col1_r;
  logic [PIX_W-1:0]          pix1_r;
  logic signed [40:0]        pcx1_r, prx1_r, pcy1_r, pry1_r;
  logic [2*CRD_W-1:0]        cr1_r;

  // Stage 2: partial sums and cross products
  logic                      v2_r, op2_r;
  logic [CRD_W-1:0]          row2_r, col2_r;
  logic [PIX_W-1:0]          pix2_r;
  sum_t                      abx2_r, aby2_r;
  logic signed [48:0]        ccx2_r, ccy2_r;

  // Stage 3: full Q36.16 coordinates, memory access
  logic                      v3_r, op3_r;
  logic [CRD_W-1:0]          row3_r, col3_r;
  logic [PIX_W-1:0]          pix3_r;
  sum_t                      sx3_r, sy3_r;

  // Output register
  logic                      out_valid_r, oor_r;
  logic [CRD_W-1:0]          orow_r, ocol_r;
  logic [PIX_W-1:0]          rd_r;

  logic [PIX_W-1:0]          mem [STORE_DEPTH];

  logic                      adv;
  logic                      x_lo, x_hi, y_lo, y_hi, outside;
  logic [COORD_W-1:0]        x_idx, y_idx;
  logic [ADDR_W-1:0]         fetch_addr, store_addr, mem_addr;
  logic                      store_ok, mem_wr;
  logic signed [SUM_W-FRAC_W-1:0] xi, yi;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kxc_r <= COEF_UNITY;
      kxr_r <= '0;
      kxx_r <= '0;
      kxo_r <= '0;
      kyc_r <= '0;
      kyr_r <= COEF_UNITY;
      kyx_r <= '0;
      kyo_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_X_COL:   kxc_r <= cfg_data;
        REG_X_ROW:   kxr_r <= cfg_data;
        REG_X_CROSS: kxx_r <= cfg_data;
        REG_X_OFF:   kxo_r <= cfg_data;
        REG_Y_COL:   kyc_r <= cfg_data;
        REG_Y_ROW:   kyr_r <= cfg_data;
        REG_Y_CROSS: kyx_r <= cfg_data;
        REG_Y_OFF:   kyo_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r && (op3_r == OP_FETCH);
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r  <= in_opcode;
      row1_r <= in_row;
      col1_r <= in_col;
      pix1_r <= in_pixel_in;
      pcx1_r <= kxc_r * $signed({1'b0, in_col});
      prx1_r <= kxr_r * $signed({1'b0, in_row});
      pcy1_r <= kyc_r * $signed({1'b0, in_col});
      pry1_r <= kyr_r * $signed({1'b0, in_row});
      cr1_r  <= in_col * in_row;

      op2_r  <= op1_r;
      row2_r <= row1_r;
      col2_r <= col1_r;
      pix2_r <= pix1_r;
      abx2_r <= SUM_W'(pcx1_r) + SUM_W'(prx1_r) + SUM_W'(kxo_r);
      aby2_r <= SUM_W'(pcy1_r) + SUM_W'(pry1_r) + SUM_W'(kyo_r);
      ccx2_r <= kxx_r * $signed({1'b0, cr1_r});
      ccy2_r <= kyx_r * $signed({1'b0, cr1_r});

      op3_r  <= op2_r;
      row3_r <= row2_r;
      col3_r <= col2_r;
      pix3_r <= pix2_r;
      sx3_r  <= abx2_r + SUM_W'(ccx2_r);
      sy3_r  <= aby2_r + SUM_W'(ccy2_r);

      orow_r <= row3_r;
      ocol_r <= col3_r;
      oor_r  <= outside;
    end
  end

  // Truncation toward zero: a value in (-1, 0) becomes zero and stays in frame,
  // so only values at or below -1.0 fall off the low edge.
  always_comb begin
    xi      = sx3_r[SUM_W-1:FRAC_W];
    yi      = sy3_r[SUM_W-1:FRAC_W];
    x_lo    = sx3_r <= -sum_t'(64'sd65536);
    y_lo    = sy3_r <= -sum_t'(64'sd65536);
    x_hi    = !sx3_r[SUM_W-1] && (xi >= (SUM_W-FRAC_W)'(FRAME_WIDTH));
    y_hi    = !sy3_r[SUM_W-1] && (yi >= (SUM_W-FRAC_W)'(FRAME_HEIGHT));
    outside = x_lo || x_hi || y_lo || y_hi;
    x_idx   = sx3_r[SUM_W-1] ? '0 : xi[COORD_W-1:0];
    y_idx   = sy3_r[SUM_W-1] ? '0 : yi[COORD_W-1:0];
    fetch_addr = ADDR_W'(32'(y_idx) * FRAME_WIDTH + 32'(x_idx));
    store_addr = ADDR_W'(32'(row3_r) * FRAME_WIDTH + 32'(col3_r));
    store_ok   = (32'(row3_r) < FRAME_HEIGHT) && (32'(col3_r) < FRAME_WIDTH);
    mem_wr     = adv && v3_r && (op3_r == OP_STORE) && store_ok;
    mem_addr   = (op3_r == OP_STORE) ? store_addr : fetch_addr;
  end

  // Stores and fetches reach the memory in acceptance order, so a fetch
  // always sees every earlier store.
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[mem_addr] <= pix3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r <= mem[mem_addr];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = orow_r;
  assign out_col       = ocol_r;
  assign out_of_range  = oor_r;
  assign out_pixel_out = oor_r ? '0 : rd_r;

`ifndef SYNTHESIS
  a_stall_only_on_held_result: assert property (
    @(posedge clk) disable iff (!rst_n) in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_fetch_reaches_output: assert property (
    @(posedge clk) disable iff (!rst_n)
    (adv && v3_r && (op3_r == OP_FETCH)) |=> out_valid)
    else $error("fetch in final stage did not produce a result");

  a_no_invented_result: assert property (
    @(posedge clk) disable iff (!rst_n)
    (adv && !(v3_r && (op3_r == OP_FETCH))) |=> !out_valid)
    else $error("result appeared without a fetch");
`endif

endmodule
